>>> rtl/core/pkf_pkg.sv
// ----------------------------------------------------------------------------
// pkf_pkg
// shared constants, types and fixed-point helpers of the pose kalman filter
// ----------------------------------------------------------------------------
package pkf_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int Q_TWO_PI     = 411775;
	localparam int Q_PI         = 205887;
	localparam int Q_HALF_PI    = 102944;
	localparam int CORDIC_GAIN  = 652032874;

	// exact quotient by 2pi via a rounded-up reciprocal, valid for 32-bit magnitudes
	localparam int    RED_SHIFT = 50;
	localparam longint RED_RECIP = ((longint'(1) <<< RED_SHIFT) + Q_TWO_PI - 1) / Q_TWO_PI;

	localparam int IN_TDATA_W  = 120;
	localparam int OUT_TDATA_W = 96;
	localparam int CFG_DATA_W  = 24;

	typedef enum logic [1:0] {
		CMD_PREDICT = 2'd0,
		CMD_MEASURE = 2'd1,
		CMD_LOAD    = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_PROCESS_NOISE    = 2'd0,
		REG_MEASURE_NOISE    = 2'd1,
		REG_INITIAL_VARIANCE = 2'd2
	} reg_idx_t;

	localparam logic signed [33:0] ATAN_Q30 [11] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
		34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
		34'sd4194283,   34'sd2097149,   34'sd1048576
	};

	function automatic logic signed [33:0] cordic_angle(input int i);
		logic signed [33:0] r;
		if (i < 11) r = ATAN_Q30[i];
		else if (i <= 30) r = 34'(longint'(1) <<< (30 - i));
		else r = '0;
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) r = 32'sh7FFF_FFFF;
		else if (v < -66'sd2147483648) r = 32'sh8000_0000;
		else r = 32'(v);
		return r;
	endfunction

	// round a q32 product to q16: add half, floor shift
	function automatic logic signed [65:0] rnd16(input logic signed [65:0] p);
		return (p + 66'sd32768) >>> 16;
	endfunction

	function automatic logic [3:0] mat_ix(input logic [1:0] r, input logic [1:0] c);
		return 4'(4'(r) * 4'd3 + 4'(c));
	endfunction

	function automatic logic [1:0] nx1(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : 2'(i + 2'd1);
	endfunction

	function automatic logic [1:0] nx2(input logic [1:0] i);
		return (i == 2'd0) ? 2'd2 : 2'(i - 2'd1);
	endfunction

endpackage

>>> rtl/core/pkf_cordic.sv
// ----------------------------------------------------------------------------
// pkf_cordic
// iterative rotation-mode cordic, q30 internally, one micro-rotation a cycle
// ----------------------------------------------------------------------------
module pkf_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [19:0] angle,
	output logic signed [31:0] cos_o,
	output logic signed [31:0] sin_o,
	output logic               done
);
	import pkf_pkg::*;

	localparam int CW = $clog2(CORDIC_STEPS);

	logic signed [33:0] x_q, y_q, z_q;
	logic [CW-1:0]      it_q;
	logic               busy_q, neg_q, done_q;
	logic signed [31:0] cos_q, sin_q;

	logic signed [20:0] a0, a1, a2, a3;
	logic               fold_neg;
	logic signed [33:0] xs, ys, ang, xn, yn, zn, xr, yr;

	// fold into [-pi/2, pi/2]
	always_comb begin
		a0 = 21'(angle);
		a1 = (a0 > 21'(Q_PI)) ? 21'(a0 - 21'(Q_TWO_PI)) : a0;
		a2 = (a1 < -21'(Q_PI)) ? 21'(a1 + 21'(Q_TWO_PI)) : a1;
		fold_neg = 1'b0;
		a3 = a2;
		if (a2 > 21'(Q_HALF_PI)) begin
			a3 = 21'(a2 - 21'(Q_PI));
			fold_neg = 1'b1;
		end else if (a2 < -21'(Q_HALF_PI)) begin
			a3 = 21'(a2 + 21'(Q_PI));
			fold_neg = 1'b1;
		end
	end

	always_comb begin
		xs  = x_q >>> it_q;
		ys  = y_q >>> it_q;
		ang = cordic_angle(int'(it_q));
		if (!z_q[33]) begin
			xn = x_q - ys;
			yn = y_q + xs;
			zn = z_q - ang;
		end else begin
			xn = x_q + ys;
			yn = y_q - xs;
			zn = z_q + ang;
		end
		xr = (xn + 34'sd8192) >>> 14;
		yr = (yn + 34'sd8192) >>> 14;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q    <= 34'(CORDIC_GAIN);
				y_q    <= '0;
				z_q    <= 34'(a3) <<< 14;
				neg_q  <= fold_neg;
				it_q   <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				x_q  <= xn;
				y_q  <= yn;
				z_q  <= zn;
				it_q <= CW'(it_q + 1'b1);
				if (it_q == CW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					cos_q  <= sat32(66'(neg_q ? -xr : xr));
					sin_q  <= sat32(66'(neg_q ? -yr : yr));
				end
			end
		end
	end

	assign cos_o = cos_q;
	assign sin_o = sin_q;
	assign done  = done_q;

endmodule

>>> rtl/core/pkf_div.sv
// ----------------------------------------------------------------------------
// pkf_div
// restoring signed divider, q16 numerator over 32-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module pkf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [47:0] num,
	input  logic signed [31:0] den,
	output logic signed [31:0] quo,
	output logic               done
);
	import pkf_pkg::*;

	localparam int NB = 48;

	logic [NB-1:0]      dvd_q;
	logic [31:0]        rem_q, dvs_q;
	logic [5:0]         cnt_q;
	logic               busy_q, neg_q, done_q;
	logic signed [31:0] quo_q;

	logic [32:0]        rem_sh;
	logic               ge;
	logic [NB-1:0]      qmag;
	logic signed [NB:0] qs;

	always_comb begin
		rem_sh = {rem_q, dvd_q[NB-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		qmag   = {dvd_q[NB-2:0], ge};
		qs     = signed'({1'b0, qmag});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q  <= num[47] ? NB'(~num + 48'd1) : NB'(num);
				dvs_q  <= den[31] ? 32'(~den + 32'd1) : 32'(den);
				neg_q  <= num[47] ^ den[31];
				rem_q  <= '0;
				cnt_q  <= 6'(NB);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
				dvd_q <= qmag;
				cnt_q <= 6'(cnt_q - 6'd1);
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					quo_q  <= sat32(66'(neg_q ? -qs : qs));
				end
			end
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

>>> rtl/core/pose_kalman_filter.sv
// ----------------------------------------------------------------------------
// pose_kalman_filter
// three-state pose kalman filter (x, y, heading), signed q16.16, shared multiplier
// ----------------------------------------------------------------------------
// channel    | dir | beat contents
// s_axis     | in  | tuser: cmd; tdata: vec_0, vec_1, vec_2, step_time
// m_axis     | out | tuser: singular; tdata: est_x, est_y, est_heading
// cfg        | in  | cfg_we, cfg_index, cfg_data (no wait, no read-back)
//
// one beat in gives one beat out; the block takes no new beat until done
// predict runs 7 multiplies on the shared multiplier, two before the cordic and five after it
// measurement runs nine divides, one per inverse entry; a singular one stops after the determinant
// load and the unused command go straight to the output; one shared 33x33 multiplier
// a finished result waits in the output register while the next beat is taken
// asynchronous active-low reset restores registers, zero pose, diagonal covariance
// ----------------------------------------------------------------------------
module pose_kalman_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// vec_0 [31:0], vec_1 [63:32], vec_2 [95:64], step_time [115:96], zero pad
	input  logic [pkf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// cmd [1:0]
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// est_x [31:0], est_y [63:32], est_heading [95:64]
	output logic [pkf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// singular [0]
	output logic                              m_axis_tuser,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [pkf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pkf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PRED_MUL, S_PRED_CORD, S_ADJ, S_DET, S_DIV,
		S_GAIN, S_UPD, S_KP, S_COV, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [CFG_DATA_W-1:0] pnoise_q, mnoise_q, ivar_q;

	// filter state and scratch matrices
	logic signed [31:0] est_q [3];
	logic signed [31:0] cov_q [9];
	logic signed [31:0] sm_q  [9];   // innovation matrix s = p + r*i
	logic signed [31:0] mx_q  [9];   // adjugate, then inverse, then k*p
	logic signed [31:0] kg_q  [9];   // kalman gain
	logic signed [31:0] e_q   [3];   // innovation
	logic signed [31:0] det_q, cdt_q, sdt_q;
	logic signed [31:0] u0_q, u1_q, u2_q;
	logic [19:0]        dt_q;
	logic [12:0]        quo2pi_q;
	logic signed [19:0] angle_q;

	// sequencer counters
	logic [1:0] row_q, col_q, term_q;
	logic [2:0] pstep_q;
	logic       ph_q;

	// shared multiply-accumulate
	logic signed [65:0] prod_s1, acc_q;
	logic signed [32:0] opa, opb;
	logic signed [65:0] term, acc_base, acc_new;
	logic signed [31:0] res_sat;
	logic               exact, sub;
	logic [1:0]         term_last;
	logic               mac_state;

	// output register
	logic                   m_valid_q, m_sing_q, sing_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// helper units
	logic               cord_go_q, cord_done, div_go_q, div_done;
	logic signed [31:0] cos_w, sin_w, div_quo;
	logic [31:0]        hmag;
	logic               out_load;

	logic signed [31:0] in_v [3];
	logic [19:0]        in_dt;

	assign in_v[0] = s_axis_tdata[31:0];
	assign in_v[1] = s_axis_tdata[63:32];
	assign in_v[2] = s_axis_tdata[95:64];
	assign in_dt   = s_axis_tdata[115:96];

	assign s_axis_tready = (state_q == S_IDLE);
	assign out_load      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

	// heading magnitude for the 2pi reduction
	assign hmag = est_q[2][31] ? 32'(~est_q[2] + 32'd1) : 32'(est_q[2]);

	pkf_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_go_q),
		.angle  (angle_q),
		.cos_o  (cos_w),
		.sin_o  (sin_w),
		.done   (cord_done)
	);

	pkf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    ({mx_q[mat_ix(row_q, col_q)], 16'h0000}),
		.den    (det_q),
		.quo    (div_quo),
		.done   (div_done)
	);

	// operand select for the multiplier
	always_comb begin
		opa = '0;
		opb = '0;
		unique case (state_q)
			S_PRED_MUL: begin
				unique case (pstep_q)
					3'd0: begin opa = 33'(hmag);      opb = 33'(RED_RECIP); end
					3'd1: begin opa = 33'(quo2pi_q);  opb = 33'(Q_TWO_PI);  end
					3'd2: begin opa = 33'(cos_w);     opb = 33'(dt_q);      end
					3'd3: begin opa = 33'(sin_w);     opb = 33'(dt_q);      end
					3'd4: begin opa = 33'(cdt_q);     opb = 33'(u1_q);      end
					3'd5: begin opa = 33'(sdt_q);     opb = 33'(u1_q);      end
					default: begin opa = 33'(dt_q);   opb = 33'(u2_q);      end
				endcase
			end
			S_ADJ: begin
				if (term_q == 2'd0) begin
					opa = 33'(sm_q[mat_ix(nx1(col_q), nx1(row_q))]);
					opb = 33'(sm_q[mat_ix(nx2(col_q), nx2(row_q))]);
				end else begin
					opa = 33'(sm_q[mat_ix(nx1(col_q), nx2(row_q))]);
					opb = 33'(sm_q[mat_ix(nx2(col_q), nx1(row_q))]);
				end
			end
			S_DET: begin
				opa = 33'(sm_q[mat_ix(2'd0, term_q)]);
				opb = 33'(mx_q[mat_ix(term_q, 2'd0)]);
			end
			S_GAIN: begin
				opa = 33'(cov_q[mat_ix(row_q, term_q)]);
				opb = 33'(mx_q[mat_ix(term_q, col_q)]);
			end
			S_UPD: begin
				opa = 33'(kg_q[mat_ix(row_q, term_q)]);
				opb = 33'(e_q[term_q]);
			end
			S_KP: begin
				opa = 33'(kg_q[mat_ix(row_q, term_q)]);
				opb = 33'(cov_q[mat_ix(term_q, col_q)]);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// accumulate: exact products for the adjugate and the angle reduction,
	// rounded products everywhere else
	always_comb begin
		exact     = (state_q == S_ADJ) || (state_q == S_PRED_MUL && pstep_q < 3'd2);
		sub       = (state_q == S_ADJ) && (term_q == 2'd1);
		term      = exact ? prod_s1 : rnd16(prod_s1);
		acc_base  = (term_q == 2'd0) ? '0 : acc_q;
		acc_new   = sub ? acc_base - term : acc_base + term;
		res_sat   = (state_q == S_ADJ) ? sat32(rnd16(acc_new)) : sat32(acc_new);
		term_last = (state_q == S_ADJ) ? 2'd1 : (state_q == S_PRED_MUL) ? 2'd0 : 2'd2;
		mac_state = (state_q == S_PRED_MUL) || (state_q == S_ADJ) || (state_q == S_DET)
		         || (state_q == S_GAIN) || (state_q == S_UPD) || (state_q == S_KP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pnoise_q  <= CFG_DATA_W'(66);
			mnoise_q  <= '0;
			ivar_q    <= CFG_DATA_W'(65536);
			for (int i = 0; i < 3; i++) est_q[i] <= '0;
			for (int i = 0; i < 9; i++)
				cov_q[i] <= (i % 4 == 0) ? 32'sd65536 : '0;
			row_q     <= '0;
			col_q     <= '0;
			term_q    <= '0;
			pstep_q   <= '0;
			ph_q      <= 1'b0;
			cord_go_q <= 1'b0;
			div_go_q  <= 1'b0;
			sing_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			cord_go_q <= 1'b0;
			div_go_q  <= 1'b0;

			// config writes, only while idle by contract
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_PROCESS_NOISE:    pnoise_q <= cfg_data;
					REG_MEASURE_NOISE:    mnoise_q <= cfg_data;
					REG_INITIAL_VARIANCE: ivar_q   <= cfg_data;
					default: ;
				endcase
			end

			if (m_valid_q && m_axis_tready && !out_load) m_valid_q <= 1'b0;

			// shared multiply, then accumulate on the next cycle
			if (mac_state) begin
				if (!ph_q) begin
					prod_s1 <= opa * opb;
					ph_q    <= 1'b1;
				end else begin
					acc_q <= acc_new;
					ph_q  <= 1'b0;
					if (term_q != term_last) begin
						term_q <= 2'(term_q + 2'd1);
					end else begin
						term_q <= '0;
						unique case (state_q)
							S_PRED_MUL: begin
								pstep_q <= 3'(pstep_q + 3'd1);
								unique case (pstep_q)
									3'd0: quo2pi_q <= 13'(acc_new >>> RED_SHIFT);
									3'd1: begin
										angle_q <= est_q[2][31]
											? 20'(-(33'(hmag) - 33'(acc_new)))
											: 20'(33'(hmag) - 33'(acc_new));
										cord_go_q <= 1'b1;
										state_q   <= S_PRED_CORD;
									end
									3'd2: cdt_q <= res_sat;
									3'd3: sdt_q <= res_sat;
									3'd4: est_q[0] <= sat32(66'(est_q[0]) + 66'(u0_q) + acc_new);
									3'd5: est_q[1] <= sat32(66'(est_q[1]) + acc_new);
									default: begin
										est_q[2] <= sat32(66'(est_q[2]) + acc_new);
										for (int i = 0; i < 3; i++)
											cov_q[i*4] <= sat32(66'(cov_q[i*4]) + 66'(pnoise_q));
										state_q <= S_OUT;
									end
								endcase
							end
							S_DET: begin
								det_q <= res_sat;
								if (res_sat == '0) begin
									sing_q  <= 1'b1;
									state_q <= S_OUT;
								end else begin
									state_q <= S_DIV;
								end
							end
							S_UPD: begin
								est_q[row_q] <= sat32(66'(est_q[row_q]) + 66'(res_sat));
								if (row_q == 2'd2) begin
									row_q   <= '0;
									state_q <= S_KP;
								end else begin
									row_q <= 2'(row_q + 2'd1);
								end
							end
							default: begin
								// one matrix entry done: adjugate, gain or k*p
								if (state_q == S_GAIN) kg_q[mat_ix(row_q, col_q)] <= res_sat;
								else mx_q[mat_ix(row_q, col_q)] <= res_sat;
								if (col_q == 2'd2) begin
									col_q <= '0;
									if (row_q == 2'd2) begin
										row_q <= '0;
										priority if (state_q == S_ADJ) state_q <= S_DET;
										else if (state_q == S_GAIN) state_q <= S_UPD;
										else state_q <= S_COV;
									end else begin
										row_q <= 2'(row_q + 2'd1);
									end
								end else begin
									col_q <= 2'(col_q + 2'd1);
								end
							end
						endcase
					end
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						sing_q  <= 1'b0;
						row_q   <= '0;
						col_q   <= '0;
						term_q  <= '0;
						ph_q    <= 1'b0;
						pstep_q <= '0;
						unique case (cmd_t'(s_axis_tuser))
							CMD_PREDICT: begin
								u0_q    <= in_v[0];
								u1_q    <= in_v[1];
								u2_q    <= in_v[2];
								dt_q    <= in_dt;
								state_q <= S_PRED_MUL;
							end
							CMD_MEASURE: begin
								for (int i = 0; i < 9; i++)
									sm_q[i] <= (i % 4 == 0)
										? sat32(66'(cov_q[i]) + 66'(mnoise_q)) : cov_q[i];
								for (int i = 0; i < 3; i++)
									e_q[i] <= sat32(66'(in_v[i]) - 66'(est_q[i]));
								state_q <= S_ADJ;
							end
							CMD_LOAD: begin
								for (int i = 0; i < 3; i++) est_q[i] <= in_v[i];
								for (int i = 0; i < 9; i++)
									cov_q[i] <= (i % 4 == 0) ? 32'(ivar_q) : '0;
								state_q <= S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_PRED_CORD: begin
					if (cord_done) state_q <= S_PRED_MUL;
				end
				S_DIV: begin
					// one inverse entry per divide
					if (!ph_q) begin
						div_go_q <= 1'b1;
						ph_q     <= 1'b1;
					end else if (div_done) begin
						ph_q <= 1'b0;
						mx_q[mat_ix(row_q, col_q)] <= div_quo;
						if (col_q == 2'd2) begin
							col_q <= '0;
							if (row_q == 2'd2) begin
								row_q   <= '0;
								state_q <= S_GAIN;
							end else begin
								row_q <= 2'(row_q + 2'd1);
							end
						end else begin
							col_q <= 2'(col_q + 2'd1);
						end
					end
				end
				S_COV: begin
					for (int i = 0; i < 9; i++)
						cov_q[i] <= sat32(66'(cov_q[i]) - 66'(mx_q[i]));
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						m_data_q  <= {est_q[2], est_q[1], est_q[0]};
						m_sing_q  <= sing_q;
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_sing_q;

	// a taken beat always starts work, so the block drops ready at once
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("ready still high after an accepted beat");

	// a singular result only comes from a zero determinant
	a_sing_det: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && sing_q) |-> (det_q == '0))
		else $error("singular flag without zero determinant");

	// the cordic is only kicked off on the way into its wait state
	a_cord_go: assert property (@(posedge clk) disable iff (!arst_n)
		cord_go_q |-> (state_q == S_PRED_CORD))
		else $error("cordic start outside predict");

	// divides are only started while inverting
	a_div_go: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> (state_q == S_DIV))
		else $error("divider start outside inverse");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pose kalman filter: commands go in as beats with
// random burst gaps, results are compared against an in-bench fixed-point
// model of predict, measurement update and load under several noise settings
// ----------------------------------------------------------------------------
module tb;
	import pkf_pkg::*;

	localparam int          LIMIT_CYCLES = 5000000;
	localparam logic [1:0]  CMD_UNUSED   = 2'd3;
	localparam logic [1:0]  REG_UNUSED   = 2'd3;
	localparam int          REG_MAX      = 24'hFFFFFF;

	typedef logic signed [65:0] wide_t;
	typedef int mat_t [9];

	typedef struct {
		logic [1:0]  cmd;
		int          v0;
		int          v1;
		int          v2;
		logic [19:0] dt;
	} pose_cmd_t;

	typedef struct {
		int   x;
		int   y;
		int   hd;
		logic sing;
	} pose_est_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pose_kalman_filter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// commands waiting to be sent and estimates waiting to come back
	pose_cmd_t pending_cmds[$];
	pose_est_t expected_ests[$];
	int        mismatches = 0;
	longint    cycle_count = 0;

	// model copy of the filter state and its registers
	int      model_q   = 66;
	int      model_r   = 0;
	int      model_iv  = 65536;
	int      model_est [3];
	mat_t    model_cov;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// fixed-point helpers: round a q32 product to q16 and clamp to 32 bits
	// ------------------------------------------------------------------------
	function automatic wide_t rnd_q16(input wide_t p);
		return (p + 66'sd32768) >>> 16;
	endfunction

	function automatic int clamp32(input wide_t v);
		if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic wide_t mul(input int a, input int b);
		return wide_t'(a) * wide_t'(b);
	endfunction

	// cordic sine/cosine of a q16.16 heading, with range reduction to +-pi/2
	function automatic void heading_trig(input int hd, output int c, output int s);
		longint r, xx, yy, zz, xs, ys, ang;
		bit flip;
		r = longint'(hd) % longint'(Q_TWO_PI);
		flip = 1'b0;
		if (r > Q_PI) r -= Q_TWO_PI;
		if (r < -Q_PI) r += Q_TWO_PI;
		if (r > Q_HALF_PI) begin
			r -= Q_PI;
			flip = 1'b1;
		end else if (r < -Q_HALF_PI) begin
			r += Q_PI;
			flip = 1'b1;
		end
		xx = CORDIC_GAIN;
		yy = 0;
		zz = r * 16384;
		for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
			xs = xx >>> i;
			ys = yy >>> i;
			if (i < 11) ang = longint'(ATAN_Q30[i]);
			else if (i <= 30) ang = longint'(1) << (30 - i);
			else ang = 0;
			if (zz >= 0) begin
				xx -= ys;
				yy += xs;
				zz -= ang;
			end else begin
				xx += ys;
				yy -= xs;
				zz += ang;
			end
		end
		xx = (xx + 8192) >>> 14;
		yy = (yy + 8192) >>> 14;
		if (flip) begin
			xx = -xx;
			yy = -yy;
		end
		c = clamp32(xx);
		s = clamp32(yy);
	endfunction

	function automatic mat_t mat_product(input mat_t a, input mat_t b);
		mat_t o;
		wide_t acc;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += rnd_q16(mul(a[i*3+k], b[k*3+j]));
				o[i*3+j] = clamp32(acc);
			end
		return o;
	endfunction

	function automatic void reset_covariance();
		for (int i = 0; i < 9; i++) model_cov[i] = 0;
		for (int i = 0; i < 3; i++) model_cov[i*4] = model_iv;
	endfunction

	// full-state update with H = I; returns 1 when the innovation matrix is singular
	function automatic bit measure_update(input int z0, input int z1, input int z2);
		mat_t sm, adj, inv, gain, gp;
		int zv [3];
		int innov [3];
		wide_t det, acc;
		int i1, i2, j1, j2;
		zv[0] = z0;
		zv[1] = z1;
		zv[2] = z2;
		sm = model_cov;
		for (int i = 0; i < 3; i++) sm[i*4] = clamp32(wide_t'(sm[i*4]) + wide_t'(model_r));
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				j1 = (j + 1) % 3;
				j2 = (j + 2) % 3;
				i1 = (i + 1) % 3;
				i2 = (i + 2) % 3;
				adj[i*3+j] = clamp32(rnd_q16(mul(sm[j1*3+i1], sm[j2*3+i2])
					- mul(sm[j1*3+i2], sm[j2*3+i1])));
			end
		det = 0;
		for (int j = 0; j < 3; j++) det += rnd_q16(mul(sm[j], adj[j*3]));
		det = wide_t'(clamp32(det));
		if (det == 0) return 1'b1;
		for (int i = 0; i < 9; i++) inv[i] = clamp32((wide_t'(adj[i]) * 66'sd65536) / det);
		gain = mat_product(model_cov, inv);
		for (int i = 0; i < 3; i++) innov[i] = clamp32(wide_t'(zv[i]) - wide_t'(model_est[i]));
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) acc += rnd_q16(mul(gain[i*3+j], innov[j]));
			model_est[i] = clamp32(wide_t'(model_est[i]) + wide_t'(clamp32(acc)));
		end
		gp = mat_product(gain, model_cov);
		for (int i = 0; i < 9; i++) model_cov[i] = clamp32(wide_t'(model_cov[i]) - wide_t'(gp[i]));
		return 1'b0;
	endfunction

	// advance the model by one command and give the estimate it reports
	function automatic pose_est_t pose_step(input pose_cmd_t c);
		pose_est_t e;
		int cs, sn, cdt, sdt;
		wide_t dt;
		e.sing = 1'b0;
		dt = wide_t'({1'b0, c.dt});
		case (c.cmd)
			CMD_PREDICT: begin
				heading_trig(model_est[2], cs, sn);
				cdt = clamp32(rnd_q16(wide_t'(cs) * dt));
				sdt = clamp32(rnd_q16(wide_t'(sn) * dt));
				model_est[0] = clamp32(wide_t'(model_est[0]) + wide_t'(c.v0) + rnd_q16(mul(cdt, c.v1)));
				model_est[1] = clamp32(wide_t'(model_est[1]) + rnd_q16(mul(sdt, c.v1)));
				model_est[2] = clamp32(wide_t'(model_est[2]) + rnd_q16(dt * wide_t'(c.v2)));
				for (int i = 0; i < 3; i++)
					model_cov[i*4] = clamp32(wide_t'(model_cov[i*4]) + wide_t'(model_q));
			end
			CMD_MEASURE: e.sing = measure_update(c.v0, c.v1, c.v2);
			CMD_LOAD: begin
				model_est[0] = c.v0;
				model_est[1] = c.v1;
				model_est[2] = c.v2;
				reset_covariance();
			end
			default: ;
		endcase
		e.x  = model_est[0];
		e.y  = model_est[1];
		e.hd = model_est[2];
		return e;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// driver: bursts of beats separated by random gaps
	// ------------------------------------------------------------------------
	pose_cmd_t drv_cmd;
	int        burst_left = 0;
	int        gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			// beat taken: predict what the block will report for it
			if (s_axis_tvalid && s_axis_tready)
				expected_ests.push_back(pose_step(drv_cmd));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					drv_cmd = pending_cmds.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {4'b0, drv_cmd.dt, drv_cmd.v2, drv_cmd.v1, drv_cmd.v0};
					s_axis_tuser  <= drv_cmd.cmd;
					if (burst_left > 0) burst_left--;
					else begin
						// start a new burst; a third of them follow with no gap
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: receiver stalls follow a random mode that is redrawn periodically as the bench counts cycles
	// ------------------------------------------------------------------------
	int        stall_mode = 0;
	int        stall_left = 0;
	pose_est_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			cycle_count++;
			if (cycle_count > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("CHECKS FAILED");
				$finish;
			end else begin
				if (m_axis_tvalid && m_axis_tready) begin
					if (expected_ests.size() == 0) begin
						report("unexpected beat", m_axis_tdata[31:0], '0);
					end else begin
						want = expected_ests.pop_front();
						if (m_axis_tdata[31:0] !== want.x)
							report("est_x", m_axis_tdata[31:0], want.x);
						if (m_axis_tdata[63:32] !== want.y)
							report("est_y", m_axis_tdata[63:32], want.y);
						if (m_axis_tdata[95:64] !== want.hd)
							report("est_heading", m_axis_tdata[95:64], want.hd);
						if (m_axis_tuser !== want.sing)
							report("singular", 32'(m_axis_tuser), 32'(want.sing));
					end
				end
				if (cycle_count % 256 == 0) stall_mode = $urandom_range(0, 2);
				case (stall_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= $urandom_range(0, 1);
					default: begin
						// long stalls with short ready windows
						if (stall_left > 0) begin
							stall_left--;
							m_axis_tready <= 1'b0;
						end else begin
							stall_left = $urandom_range(0, 3) == 0 ? $urandom_range(5, 40) : 0;
							m_axis_tready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	task automatic send(input logic [1:0] cmd, input int v0, input int v1, input int v2,
		input logic [19:0] dt);
		pose_cmd_t c;
		c.cmd = cmd;
		c.v0  = v0;
		c.v1  = v1;
		c.v2  = v2;
		c.dt  = dt;
		pending_cmds.push_back(c);
	endtask

	// block settled: nothing queued, nothing on the bus, nothing outstanding
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || s_axis_tvalid || expected_ests.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		case (idx)
			REG_PROCESS_NOISE:    model_q  = val & REG_MAX;
			REG_MEASURE_NOISE:    model_r  = val & REG_MAX;
			REG_INITIAL_VARIANCE: model_iv = val & REG_MAX;
			default: ;
		endcase
	endtask

	task automatic set_noise(input int q, input int r, input int iv);
		write_reg(REG_PROCESS_NOISE, q);
		write_reg(REG_MEASURE_NOISE, r);
		write_reg(REG_INITIAL_VARIANCE, iv);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly realistic magnitudes (about +-10.0), sometimes the full range
	function automatic int pick_val();
		if ($urandom_range(0, 9) == 0) return int'($urandom());
		return int'($urandom_range(0, 1310720)) - 655360;
	endfunction

	function automatic logic [19:0] pick_dt();
		if ($urandom_range(0, 9) == 0) return 20'($urandom());
		return 20'($urandom_range(0, 6554));
	endfunction

	function automatic int pick_reg();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 200);
			1: return $urandom_range(0, 131072);
			2: return int'($urandom_range(0, REG_MAX));
			default: return 66;
		endcase
	endfunction

	// well-formed tracks (load then predicts and fixes) plus a share of noise
	task automatic random_items(input int n);
		int sent, run;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 4) != 0) begin
				send(CMD_LOAD, pick_val(), pick_val(), pick_val(), pick_dt());
				run = $urandom_range(2, 12);
				for (int i = 0; i < run; i++)
					if ($urandom_range(0, 2) == 0)
						send(CMD_MEASURE, pick_val(), pick_val(), pick_val(), pick_dt());
					else
						send(CMD_PREDICT, pick_val(), pick_val(), pick_val(), pick_dt());
				sent += run + 1;
			end else begin
				send(2'($urandom_range(0, 3)), int'($urandom()), int'($urandom()),
					int'($urandom()), 20'($urandom()));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		model_est = '{0, 0, 0};
		reset_covariance();
		repeat (8) @(posedge clk);
		arst_n = 1'b1;

		// directed part under the reset settings
		send(CMD_PREDICT, 0, 0, 0, 20'd0);
		send(CMD_PREDICT, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 20'hFFFFF);
		send(CMD_PREDICT, 32'sh80000000, 32'sh80000000, 32'sh80000000, 20'hFFFFF);
		send(CMD_MEASURE, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 20'd0);
		send(CMD_LOAD, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 20'hFFFFF);
		send(CMD_MEASURE, 32'sh80000000, 32'sh7FFFFFFF, 0, 20'd0);
		// headings just past +pi/2, at -pi and several turns out exercise the quadrant fold
		send(CMD_LOAD, 0, 0, Q_HALF_PI + 1, 20'd0);
		send(CMD_PREDICT, 65536, 65536, 0, 20'd65536);
		send(CMD_LOAD, 0, 0, -Q_PI, 20'd0);
		send(CMD_PREDICT, 0, 131072, 65536, 20'd6554);
		send(CMD_LOAD, 0, 0, 3 * Q_TWO_PI + 1000, 20'd0);
		send(CMD_PREDICT, -65536, 65536, -65536, 20'd655);
		send(CMD_MEASURE, 65536, -65536, 13107, 20'd0);
		send(CMD_UNUSED, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 20'hFFFFF);
		wait_idle();

		// all-zero noise and variance: the innovation matrix cannot be inverted
		set_noise(0, 0, 0);
		send(CMD_LOAD, 65536, 131072, 32768, 20'd0);
		send(CMD_MEASURE, 0, 0, 0, 20'd0);
		send(CMD_PREDICT, 65536, 65536, 65536, 20'd65536);
		send(CMD_MEASURE, 1, 1, 1, 20'd0);
		send(CMD_UNUSED, 0, 0, 0, 20'd0);
		wait_idle();

		// register maxima, plus a write to the unused index that must do nothing
		set_noise(REG_MAX, REG_MAX, REG_MAX);
		write_reg(REG_UNUSED, 0);
		@(posedge clk);
		cfg_we <= 1'b0;
		send(CMD_LOAD, 0, 0, 0, 20'd0);
		send(CMD_PREDICT, 65536, 65536, 65536, 20'hFFFFF);
		send(CMD_MEASURE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 20'd0);
		send(CMD_PREDICT, 0, 0, 0, 20'd1);
		wait_idle();

		// random phases, each under its own register settings
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 1) set_noise(0, 0, 0);
			else if (ph == 4) set_noise(REG_MAX, REG_MAX, REG_MAX);
			else set_noise(pick_reg(), pick_reg(), pick_reg());
			random_items(210);
			wait_idle();
		end

		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> pose_kalman_filter.f
rtl/core/pkf_pkg.sv
rtl/core/pkf_cordic.sv
rtl/core/pkf_div.sv
rtl/core/pose_kalman_filter.sv
tb/tb.sv
